/* hw/rtl/gbds_pkg.sv */
// Package: shared types, register map and constants of the Gillespie step unit.
package gbds_pkg;

    // replicate count and table index width
    localparam int REPLICATES = 8;
    localparam int REP_W      = 3;

    // configuration port geometry
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_CROWDING   = 3'd0;
    localparam logic [2:0] REG_DEATH      = 3'd1;
    localparam logic [2:0] REG_GAIN_SAME  = 3'd2;
    localparam logic [2:0] REG_GAIN_OTHER = 3'd3;
    localparam logic [2:0] REG_OTHER_POP  = 3'd4;

    // event codes
    localparam logic [1:0] EV_DEATH = 2'd0;
    localparam logic [1:0] EV_BIRTH = 2'd1;
    localparam logic [1:0] EV_NONE  = 2'd2;

    // ln(2) in Q.32
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    // 1.0 in Q.32
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    // reset values of the registers
    localparam logic [47:0] CROWDING_RST = 48'd42950;
    localparam logic [47:0] DEATH_RST    = 48'h0001_0000_0000;
    localparam logic [47:0] GAIN_RST     = 48'h0001_0000_0000;

    typedef struct packed {
        logic [REP_W-1:0] replicate;
        logic [31:0]      time_uniform;
        logic [31:0]      choice_uniform;
    } item_t;

    typedef struct packed {
        logic [REP_W-1:0] replicate_out;
        logic [31:0]      population;
        logic [63:0]      sim_time;
        logic [1:0]       event_res;
    } result_t;

endpackage

/* hw/rtl/gillespie_birth_death_step_unit.sv */
// Top level: Gillespie direct-method step over a shared multiplier and divider.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------
//  item     | in        | item_valid / item_stall   | item (gbds_pkg::item_t)
//  result   | out       | result_valid/result_stall | result (gbds_pkg::result_t)
//  config   | in/out    | psel/penable/pwrite/pready| paddr, pwdata, prdata (64 bit)
//
// A full beat runs nine multiplies and 32 squarings
// on one 32x32 multiplier (one setup state plus ST_MUL, four partial products),
// and three restoring divisions (one check, 64 quotient bits).
// Extinct steps go from the check straight to the result; zero-rate steps stop after
// five or six multiplies and two divisions.
// item_stall is high from acceptance until the result beat is taken.
// Reset restores the registers, sets every population to one and every time
// to zero; no clearing pass is needed.
module gillespie_birth_death_step_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  gbds_pkg::item_t          item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output gbds_pkg::result_t        result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [gbds_pkg::ADDR_W-1:0] paddr,
    input  logic [gbds_pkg::DATA_W-1:0] pwdata,
    output logic [gbds_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);
    import gbds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_BNC, ST_BC, ST_GS, ST_GSD, ST_GO, ST_GOD,
        ST_BIRTH, ST_TOTAL, ST_SQ, ST_LGH, ST_LGL, ST_TAU, ST_CHOOSE,
        ST_DECIDE, ST_MUL, ST_DIVCHK, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg, ret_reg;

    // configuration
    logic [47:0] crowding_reg, death_reg, gain_same_reg, gain_other_reg;
    logic [31:0] other_pop_reg;

    // replicate state
    logic [31:0] pop_store [REPLICATES];
    logic [63:0] time_store [REPLICATES];

    // per-beat working registers
    logic [REP_W-1:0] rep_reg;
    logic [31:0]      r1_reg, r2_reg, c_reg;
    logic [32:0]      n_reg;
    logic [63:0]      a1_reg, a0_reg, f_reg, lg_reg, l_reg, time_reg;
    logic [31:0]      frac_reg;
    logic [4:0]       p_reg, sq_cnt_reg;
    result_t          result_reg;

    // shared multiplier
    logic [63:0]  opa_reg, opb_reg, pp_reg;
    logic [127:0] acc_reg;
    logic [2:0]   mcnt_reg;
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  pp_next;
    logic [127:0] pp_shift, acc_sum;

    // shared divider
    logic [63:0] rem_reg, dlo_reg, dd_reg, q_reg;
    logic [5:0]  dcnt_reg;
    logic [63:0] rem_sh, rem_new;
    logic        take;

    // datapath helpers
    logic [63:0] acc_sat, gs_ext, go_ext, gs_mag, go_mag, q_signed_gs, q_signed_go;
    logic [63:0] f_new, a0_next, a1_sum, time_sum, lg_next, l_sum;
    logic        a0_carry, a1_carry, t_carry, f_pos, death;
    logic [31:0] r1_eff, x_init, xs_lo;
    logic [32:0] xs;
    logic [4:0]  p_enc;
    logic [32:0] n_comb;
    logic        wr_en;

    // pick the partial product for this multiplier step
    always_comb
    begin
        case (mcnt_reg)
            3'd0:    begin mul_x = opa_reg[31:0];  mul_y = opb_reg[31:0];  end
            3'd1:    begin mul_x = opa_reg[63:32]; mul_y = opb_reg[31:0];  end
            3'd2:    begin mul_x = opa_reg[31:0];  mul_y = opb_reg[63:32]; end
            default: begin mul_x = opa_reg[63:32]; mul_y = opb_reg[63:32]; end
        endcase
        pp_next = mul_x * mul_y;
        case (mcnt_reg)
            3'd1:    pp_shift = {64'd0, pp_reg};
            3'd2:    pp_shift = {32'd0, pp_reg, 32'd0};
            3'd3:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
        acc_sum = acc_reg + pp_shift;
    end

    // one restoring division step
    always_comb
    begin
        rem_sh  = {rem_reg[62:0], dlo_reg[63]};
        take    = rem_reg[63] | (rem_sh >= dd_reg);
        rem_new = take ? (rem_sh - dd_reg) : rem_sh;
    end

    // rate arithmetic around the shared units
    always_comb
    begin
        acc_sat = (acc_reg[127:64] != 64'd0) ? '1 : acc_reg[63:0];
        gs_ext  = {{16{gain_same_reg[47]}}, gain_same_reg};
        go_ext  = {{16{gain_other_reg[47]}}, gain_other_reg};
        gs_mag  = gain_same_reg[47] ? (~gs_ext + 64'd1) : gs_ext;
        go_mag  = gain_other_reg[47] ? (~go_ext + 64'd1) : go_ext;
        q_signed_gs = gain_same_reg[47] ? (~q_reg + 64'd1) : q_reg;
        q_signed_go = gain_other_reg[47] ? (~q_reg + 64'd1) : q_reg;
        f_new   = f_reg + q_signed_go;
        f_pos   = !f_new[63] && (f_new != 64'd0);
        {a1_carry, a1_sum}   = {1'b0, a1_reg} + {1'b0, acc_sat};
        {a0_carry, a0_next}  = {1'b0, a1_reg} + {1'b0, acc_sat};
        {t_carry, time_sum}  = {1'b0, time_reg} + {1'b0, q_reg};
        n_comb  = {1'b0, pop_store[rep_reg]} + {1'b0, other_pop_reg};
        lg_next = {26'd0, 6'd32 - {1'b0, p_reg}, 32'd0} - {32'd0, frac_reg};
        l_sum   = l_reg + {32'd0, acc_reg[63:32]};
        death   = acc_reg < {32'd0, a1_reg, 32'd0};
    end

    // normalize r1 for the log
    always_comb
    begin
        r1_eff = (r1_reg == 32'd0) ? 32'd1 : r1_reg;
        p_enc  = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (r1_eff[i])
            begin
                p_enc = 5'(i);
            end
        end
        x_init = r1_eff << (5'd31 - p_enc);
        xs     = acc_reg[63:31];
        xs_lo  = xs[32] ? xs[32:1] : xs[31:0];
    end

    assign wr_en        = psel && penable && pwrite;
    assign pready       = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign result       = result_reg;

    // register read
    always_comb
    begin
        case (paddr[5:3])
            REG_CROWDING:   prdata = {16'd0, crowding_reg};
            REG_DEATH:      prdata = {16'd0, death_reg};
            REG_GAIN_SAME:  prdata = {16'd0, gain_same_reg};
            REG_GAIN_OTHER: prdata = {16'd0, gain_other_reg};
            REG_OTHER_POP:  prdata = {32'd0, other_pop_reg};
            default:        prdata = '0;
        endcase
    end

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crowding_reg   <= CROWDING_RST;
            death_reg      <= DEATH_RST;
            gain_same_reg  <= GAIN_RST;
            gain_other_reg <= GAIN_RST;
            other_pop_reg  <= 32'd0;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                REG_CROWDING:   crowding_reg   <= pwdata[47:0];
                REG_DEATH:      death_reg      <= pwdata[47:0];
                REG_GAIN_SAME:  gain_same_reg  <= pwdata[47:0];
                REG_GAIN_OTHER: gain_other_reg <= pwdata[47:0];
                REG_OTHER_POP:  other_pop_reg  <= pwdata[31:0];
                default:        ;
            endcase
        end
    end

    // sequencer, shared units and replicate tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            mcnt_reg  <= 3'd0;
            dcnt_reg  <= 6'd0;
            for (int i = 0; i < REPLICATES; i++)
            begin
                pop_store[i]  <= 32'd1;
                time_store[i] <= 64'd0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        rep_reg   <= item.replicate;
                        r1_reg    <= item.time_uniform;
                        r2_reg    <= item.choice_uniform;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    result_reg.replicate_out <= rep_reg;
                    result_reg.event_res     <= EV_NONE;
                    if (32'(rep_reg) >= 32'(REPLICATES))
                    begin
                        result_reg.population <= 32'd0;
                        result_reg.sim_time   <= 64'd0;
                        state_reg             <= ST_OUT;
                    end
                    else
                    begin
                        c_reg    <= pop_store[rep_reg];
                        time_reg <= time_store[rep_reg];
                        n_reg    <= n_comb;
                        result_reg.population <= pop_store[rep_reg];
                        result_reg.sim_time   <= time_store[rep_reg];
                        if (pop_store[rep_reg] == 32'd0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            // beta * N
                            opa_reg <= {16'd0, crowding_reg};
                            opb_reg <= {31'd0, n_comb};
                            acc_reg <= '0; mcnt_reg <= 3'd0;
                            ret_reg <= ST_BNC; state_reg <= ST_MUL;
                        end
                    end
                end
                ST_BNC:
                begin
                    opa_reg <= acc_sat;
                    opb_reg <= {32'd0, c_reg};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_BC; state_reg <= ST_MUL;
                end
                ST_BC:
                begin
                    a1_reg  <= acc_sat;
                    opa_reg <= {16'd0, death_reg};
                    opb_reg <= {32'd0, c_reg};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_GS; state_reg <= ST_MUL;
                end
                ST_GS:
                begin
                    a1_reg  <= a1_carry ? '1 : a1_sum;
                    opa_reg <= gs_mag;
                    opb_reg <= {32'd0, c_reg};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_GSD; state_reg <= ST_MUL;
                end
                ST_GSD:
                begin
                    rem_reg <= acc_reg[127:64]; dlo_reg <= acc_reg[63:0];
                    dd_reg  <= {31'd0, n_reg};
                    ret_reg <= ST_GO; state_reg <= ST_DIVCHK;
                end
                ST_GO:
                begin
                    f_reg   <= ONE_Q32 + q_signed_gs;
                    opa_reg <= go_mag;
                    opb_reg <= {32'd0, other_pop_reg};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_GOD; state_reg <= ST_MUL;
                end
                ST_GOD:
                begin
                    rem_reg <= acc_reg[127:64]; dlo_reg <= acc_reg[63:0];
                    dd_reg  <= {31'd0, n_reg};
                    ret_reg <= ST_BIRTH; state_reg <= ST_DIVCHK;
                end
                ST_BIRTH:
                begin
                    // clamp a negative birth factor at zero
                    if (f_pos)
                    begin
                        opa_reg <= f_new;
                        opb_reg <= {32'd0, c_reg};
                        acc_reg <= '0; mcnt_reg <= 3'd0;
                        ret_reg <= ST_TOTAL; state_reg <= ST_MUL;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        state_reg <= ST_TOTAL;
                    end
                end
                ST_TOTAL:
                begin
                    a0_reg <= a0_carry ? '1 : a0_next;
                    if (!a0_carry && a0_next == 64'd0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        p_reg      <= p_enc;
                        frac_reg   <= 32'd0;
                        sq_cnt_reg <= 5'd0;
                        opa_reg    <= {32'd0, x_init};
                        opb_reg    <= {32'd0, x_init};
                        acc_reg    <= '0; mcnt_reg <= 3'd0;
                        ret_reg    <= ST_SQ; state_reg <= ST_MUL;
                    end
                end
                ST_SQ:
                begin
                    // one fraction bit of log2 per squaring
                    frac_reg   <= {frac_reg[30:0], xs[32]};
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_LGH;
                    end
                    else
                    begin
                        opa_reg <= {32'd0, xs_lo};
                        opb_reg <= {32'd0, xs_lo};
                        acc_reg <= '0; mcnt_reg <= 3'd0;
                        ret_reg <= ST_SQ; state_reg <= ST_MUL;
                    end
                end
                ST_LGH:
                begin
                    lg_reg  <= lg_next;
                    opa_reg <= {32'd0, lg_next[63:32]};
                    opb_reg <= {32'd0, LN2_Q32};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_LGL; state_reg <= ST_MUL;
                end
                ST_LGL:
                begin
                    l_reg   <= acc_reg[63:0];
                    opa_reg <= {32'd0, lg_reg[31:0]};
                    opb_reg <= {32'd0, LN2_Q32};
                    acc_reg <= '0; mcnt_reg <= 3'd0;
                    ret_reg <= ST_TAU; state_reg <= ST_MUL;
                end
                ST_TAU:
                begin
                    // tau = L * 2^32 / a0
                    rem_reg <= {32'd0, l_sum[63:32]};
                    dlo_reg <= {l_sum[31:0], 32'd0};
                    dd_reg  <= a0_reg;
                    ret_reg <= ST_CHOOSE; state_reg <= ST_DIVCHK;
                end
                ST_CHOOSE:
                begin
                    time_reg <= t_carry ? '1 : time_sum;
                    opa_reg  <= a0_reg;
                    opb_reg  <= {32'd0, r2_reg};
                    acc_reg  <= '0; mcnt_reg <= 3'd0;
                    ret_reg  <= ST_DECIDE; state_reg <= ST_MUL;
                end
                ST_DECIDE:
                begin
                    time_store[rep_reg]  <= time_reg;
                    result_reg.sim_time  <= time_reg;
                    if (death)
                    begin
                        pop_store[rep_reg]    <= c_reg - 32'd1;
                        result_reg.population <= c_reg - 32'd1;
                        result_reg.event_res  <= EV_DEATH;
                    end
                    else
                    begin
                        result_reg.event_res <= EV_BIRTH;
                        if (c_reg != 32'hFFFF_FFFF)
                        begin
                            pop_store[rep_reg]    <= c_reg + 32'd1;
                            result_reg.population <= c_reg + 32'd1;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_MUL:
                begin
                    if (mcnt_reg != 3'd4)
                    begin
                        pp_reg <= pp_next;
                    end
                    if (mcnt_reg != 3'd0)
                    begin
                        acc_reg <= acc_sum;
                    end
                    if (mcnt_reg == 3'd4)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        mcnt_reg <= mcnt_reg + 3'd1;
                    end
                end
                ST_DIVCHK:
                begin
                    // saturate when the quotient would need 65 bits
                    dcnt_reg <= 6'd0;
                    if (rem_reg >= dd_reg)
                    begin
                        q_reg     <= '1;
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_new;
                    dlo_reg  <= {dlo_reg[62:0], 1'b0};
                    q_reg    <= {q_reg[62:0], take};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd63)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                ST_OUT:
                begin
                    if (!result_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // multiplier step count never runs past the last partial product
    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> mcnt_reg <= 3'd4)
        else $error("multiplier step count out of range");

    // restoring divider keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < dd_reg)
        else $error("divider remainder not below divisor");

    // squaring operand stays normalized in [1,2)
    a_sq_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && ret_reg == ST_SQ) |->
            (opa_reg[31] && opa_reg[63:32] == 32'd0))
        else $error("log operand not normalized");

    // a result beat leaves the input side blocked until taken
    a_out_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item accepted while result pending");

endmodule

/* bench/tb_top.sv */
// Testbench for the Gillespie step unit: directed and random steps against a predictor.
module tb_top;
    import gbds_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    gillespie_birth_death_step_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor copy of the registers and the replicate tables
    logic [63:0]        crowd_m;
    logic [63:0]        death_m;
    logic signed [63:0] gain_same_m;
    logic signed [63:0] gain_other_m;
    logic [63:0]        other_pop_m;
    logic [31:0]        pop_tab [REPLICATES];
    logic [63:0]        time_tab [REPLICATES];

    item_t   step_q [$];
    result_t outcome_q [$];
    int      err_cnt;
    int      mismatch_cnt;
    int      accepted_cnt;
    bit      hold_steps;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // gain * k / n truncated toward zero
    function automatic logic [63:0] gain_share(logic [63:0] g, logic [63:0] k,
                                              logic [63:0] n);
        logic [63:0]  mag;
        logic [127:0] q;
        mag = g[63] ? -g : g;
        q = ({64'd0, mag} * {64'd0, k}) / {64'd0, n};
        return g[63] ? -q[63:0] : q[63:0];
    endfunction

    // ln(2^32 / r) in Q.32 by repeated squaring
    function automatic logic [63:0] ln_inverse(logic [31:0] r);
        int          p;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] lg;
        if (r == 0)
            r = 32'd1;
        p = 31;
        while (p > 0 && !r[p])
            p--;
        x = {32'd0, r} << (31 - p);
        frac = 64'd0;
        for (int i = 0; i < 32; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        lg = (64'd32 << 32) - ((64'(p) << 32) + frac);
        return 64'(lg[63:32]) * 64'(LN2_Q32) + ((64'(lg[31:0]) * 64'(LN2_Q32)) >> 32);
    endfunction

    // advance one replicate and form its expected result
    function automatic result_t step_population(item_t it);
        result_t            r;
        logic [63:0]        c;
        logic [63:0]        n;
        logic [63:0]        a1;
        logic [63:0]        a2;
        logic [63:0]        a0;
        logic [63:0]        ln_v;
        logic [127:0]       num;
        logic [63:0]        tau;
        logic signed [63:0] f;
        logic [1:0]         ev;
        ev = EV_NONE;
        c = 64'(pop_tab[it.replicate]);
        if (c != 0)
        begin
            n = c + other_pop_m;
            a1 = sat_add(sat_mul(sat_mul(crowd_m, n), c), sat_mul(death_m, c));
            f = $signed(ONE_Q32) + $signed(gain_share(gain_same_m, c, n))
                + $signed(gain_share(gain_other_m, other_pop_m, n));
            a2 = (f > 0) ? sat_mul(f, c) : 64'd0;
            a0 = sat_add(a1, a2);
            if (a0 != 0)
            begin
                ln_v = ln_inverse(it.time_uniform);
                num = {64'd0, ln_v} << 32;
                tau = (num[127:64] >= a0) ? '1 : 64'(num / {64'd0, a0});
                time_tab[it.replicate] = sat_add(time_tab[it.replicate], tau);
                if (({64'd0, a0} * {96'd0, it.choice_uniform}) < ({64'd0, a1} << 32))
                begin
                    ev = EV_DEATH;
                    pop_tab[it.replicate] = pop_tab[it.replicate] - 32'd1;
                end
                else
                begin
                    ev = EV_BIRTH;
                    if (pop_tab[it.replicate] != '1)
                        pop_tab[it.replicate] = pop_tab[it.replicate] + 32'd1;
                end
            end
        end
        r.replicate_out = it.replicate;
        r.population    = pop_tab[it.replicate];
        r.sim_time      = time_tab[it.replicate];
        r.event_res     = ev;
        return r;
    endfunction

    // one quiet stretch, otherwise idle with a chance of about 31 in 100
    function automatic bit idle_now();
        if (accepted_cnt >= 700 && accepted_cnt < 1000)
            return 1'b0;
        return $urandom_range(99) < 31;
    endfunction

    // driver: predict on acceptance, present the next step when free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                outcome_q.push_back(step_population(step_q.pop_front()));
                accepted_cnt++;
            end
            if (!item_valid || !item_stall)
            begin
                if (step_q.size() > 0 && !hold_steps && !idle_now())
                begin
                    item_valid <= 1'b1;
                    item       <= step_q[0];
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: stall at random, compare each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    err_cnt++;
                    $display("unexpected result beat: rep %0d", result.replicate_out);
                end
                else
                begin
                    e = outcome_q.pop_front();
                    if (result.replicate_out !== e.replicate_out
                        || result.population !== e.population
                        || result.sim_time !== e.sim_time
                        || result.event_res !== e.event_res)
                    begin
                        err_cnt++;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: exp rep %0d pop %0d t %h ev %0d, ",
                                      "got rep %0d pop %0d t %h ev %0d"},
                                     e.replicate_out, e.population, e.sim_time, e.event_res,
                                     result.replicate_out, result.population,
                                     result.sim_time, result.event_res);
                    end
                end
            end
            result_stall <= idle_now();
        end
    end

    // write one register over the config port and mirror it in the predictor
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CROWDING:   crowd_m = {16'd0, val[47:0]};
            REG_DEATH:      death_m = {16'd0, val[47:0]};
            REG_GAIN_SAME:  gain_same_m = {{16{val[47]}}, val[47:0]};
            REG_GAIN_OTHER: gain_other_m = {{16{val[47]}}, val[47:0]};
            REG_OTHER_POP:  other_pop_m = {32'd0, val[31:0]};
            default: ;
        endcase
    endtask

    task automatic write_all(logic [63:0] cr, logic [63:0] dr, logic [63:0] gs,
                             logic [63:0] go, logic [63:0] op);
        reg_write(REG_CROWDING, cr);
        reg_write(REG_DEATH, dr);
        reg_write(REG_GAIN_SAME, gs);
        reg_write(REG_GAIN_OTHER, go);
        reg_write(REG_OTHER_POP, op);
    endtask

    // release the sender, wait until every predicted result has arrived, then let the unit settle
    task automatic drain();
        hold_steps = 1'b0;
        @(negedge clk);
        while (step_q.size() > 0 || item_valid || outcome_q.size() > 0)
            @(negedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic add_step(logic [2:0] rep, logic [31:0] r1, logic [31:0] r2);
        item_t it;
        it.replicate      = rep;
        it.time_uniform   = r1;
        it.choice_uniform = r2;
        step_q.push_back(it);
    endtask

    task automatic add_random(int count);
        repeat (count)
            add_step(3'($urandom_range(7)), $urandom, $urandom);
    endtask

    function automatic logic [63:0] rand48();
        return {16'd0, 16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [63:0] rand_gain();
        logic [63:0] g;
        if ($urandom_range(3) == 0)
            g = rand48();
        else
            g = 64'($urandom_range(0, 32'h3_FFFF)) << 14;
        if ($urandom_range(1))
            g = -g;
        return g;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_cnt = 0;
        mismatch_cnt = 0;
        accepted_cnt = 0;
        hold_steps = 1'b1;
        crowd_m = 64'(CROWDING_RST);
        death_m = 64'(DEATH_RST);
        gain_same_m = 64'(GAIN_RST);
        gain_other_m = 64'(GAIN_RST);
        other_pop_m = 64'd0;
        for (int i = 0; i < REPLICATES; i++)
        begin
            pop_tab[i] = 32'd1;
            time_tab[i] = 64'd0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-like rates: drive replicate zero to extinction, then step it again
        write_all(64'(CROWDING_RST), 64'(DEATH_RST), 64'(GAIN_RST), 64'(GAIN_RST), 64'd0);
        add_step(3'd0, 32'd1, 32'd0);
        add_step(3'd0, 32'hFFFF_FFFF, 32'd5);
        add_step(3'd1, 32'd0, 32'hFFFF_FFFF);
        add_step(3'd1, 32'd1, 32'hFFFF_FFFF);
        add_step(3'd1, 32'hFFFF_FFFF, 32'd0);
        add_step(3'd7, 32'h8000_0000, 32'h8000_0000);
        add_step(3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // largest rates and largest second population
        write_all(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF,
                  64'h7FFF_FFFF_FFFF, 64'hFFFF_FFFF);
        add_step(3'd3, 32'd1, 32'd0);
        add_step(3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_step(3'd4, 32'd0, 32'h7FFF_FFFF);
        drain();

        // most negative gains: birth factor clamped, total rate zero
        write_all(64'd0, 64'd0, 64'hFFFF_8000_0000_0000, 64'hFFFF_8000_0000_0000, 64'd3);
        add_step(3'd5, 32'd1, 32'd0);
        add_step(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // tiny death rate only: waiting time overflows and time saturates
        write_all(64'd0, 64'd1, 64'hFFFF_8000_0000_0000, 64'hFFFF_8000_0000_0000, 64'd5);
        add_step(3'd6, 32'd1, 32'hFFFF_FFFF);
        add_step(3'd6, 32'd1, 32'd0);
        add_step(3'd5, 32'd77, 32'h1234_5678);
        drain();

        // random phases over several rate settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_all(($urandom_range(4) == 0) ? rand48() : 64'($urandom_range(0, 200000)),
                      ($urandom_range(4) == 0) ? rand48() : 64'($urandom) << 1,
                      rand_gain(), rand_gain(),
                      ($urandom_range(4) == 0) ? 64'($urandom) : 64'($urandom_range(0, 40)));
            add_random(205);
            drain();
        end

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // give up after a generous bound
    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/gbds_pkg.sv
hw/rtl/gillespie_birth_death_step_unit.sv
bench/tb_top.sv
